// ===== sv/sensor_window_stats_trend_defines.svh =====
// Assertion helpers for the checker file.
`ifndef SENSOR_WINDOW_STATS_TREND_DEFINES_SVH
`define SENSOR_WINDOW_STATS_TREND_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SWST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swst assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SWST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swst assertion failed");

`endif

// ===== sv/swst_pkg.sv =====
package swst_pkg;

    localparam int WINDOW_LEN = 5;
    localparam int SAMPLE_W   = 10;
    localparam int GAIN_W     = 16;
    localparam int VAL_W      = 26;
    localparam int SUM_W      = VAL_W + $clog2(WINDOW_LEN);
    localparam int PROD_W     = 2 * SUM_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    // floor(2^SUM_W / WINDOW_LEN); the estimate it gives is low by at most one
    localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SUM_W) / WINDOW_LEN);

    localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd1999;
    localparam logic [VAL_W-1:0]  THRESHOLD_RST = 26'd410;
    localparam logic              INVERT_RST    = 1'b0;

    localparam logic [1:0] REG_GAIN      = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_INVERT    = 2'd2;

    typedef enum logic [1:0] {
        TREND_STABLE  = 2'd0,
        TREND_RISING  = 2'd1,
        TREND_FALLING = 2'd2
    } trend_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [VAL_W-1:0]  threshold;
        logic              invert;
    } swst_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

// ===== sv/swst_ifs.sv =====
interface swst_in_if
    import swst_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swst_out_if
    import swst_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] mean;
    logic [VAL_W-1:0] minimum;
    logic [VAL_W-1:0] maximum;
    trend_t           trend;

    modport source (output valid, output value, output mean, output minimum,
                    output maximum, output trend, input ready);
    modport sink   (input valid, input value, input mean, input minimum,
                    input maximum, input trend, output ready);
endinterface

// ===== sv/sensor_window_stats_trend.sv =====
// Windowed statistics of a scaled converter sample. Each word on "samples" carries one
// 10-bit converter code; the block scales it by the Q4.12 gain register into a 26-bit
// Q.12 value and returns one word on "results" per sample, in order: the value, the
// truncated mean over the last five values (slots never written count as zero), the
// lowest and highest values since reset, and a trend code (0 stable, 1 rising,
// 2 falling, swapped by trend_invert) from the newest value against the previous one
// with an exclusive dead band. Sustained rate is one word per clock while the output is
// not stalled; a result passes the holding stage, the queue, stage 1, stage 2 and the
// output register. The rate is set by the statistics pipeline, which updates the window
// at most once per clock. A four-word queue sits between the scaling front and the
// statistics back, so a stall on the result side backs up into the queue before it
// reaches "samples". Registers on the APB port: gain at 0x0, trend_threshold at 0x4,
// trend_invert at 0x8; write them only while no word is in flight.
module sensor_window_stats_trend
    import swst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    swst_in_if.sink           samples,
    swst_out_if.source        results,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    swst_cfg_t        cfg;
    fifo_status_t     fifo_status;
    logic             push;
    logic [VAL_W-1:0] push_value;
    logic             pop;
    logic [VAL_W-1:0] head_value;

    // register file, always ready
    swst_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // front: take the sample, scale by gain on the way into the queue
    swst_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples),
        .gain        (cfg.gain),
        .fifo_status (fifo_status),
        .push        (push),
        .push_value  (push_value)
    );

    // decoupling queue of scaled values
    swst_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (push_value),
        .pop    (pop),
        .rdata  (head_value),
        .status (fifo_status)
    );

    // back: window, running sum, min/max, trend, then mean by reciprocal multiply
    swst_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .fifo_status (fifo_status),
        .head_value  (head_value),
        .pop         (pop),
        .results     (results)
    );

endmodule

// ===== sv/swst_regs.sv =====
module swst_regs
    import swst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output swst_cfg_t         cfg
);

    swst_cfg_t  cfg_reg;
    logic [1:0] idx;
    logic       wr_en;

    assign idx    = paddr[3:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain      <= GAIN_RST;
            cfg_reg.threshold <= THRESHOLD_RST;
            cfg_reg.invert    <= INVERT_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_GAIN:      cfg_reg.gain      <= pwdata[GAIN_W-1:0];
                REG_THRESHOLD: cfg_reg.threshold <= pwdata[VAL_W-1:0];
                REG_INVERT:    cfg_reg.invert    <= pwdata[0];
                default:       ;   // unmapped, dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GAIN:      prdata = DATA_W'(cfg_reg.gain);
            REG_THRESHOLD: prdata = DATA_W'(cfg_reg.threshold);
            REG_INVERT:    prdata = DATA_W'(cfg_reg.invert);
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== sv/swst_front.sv =====
module swst_front
    import swst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    swst_in_if.sink           samples,
    input  logic [GAIN_W-1:0] gain,
    input  fifo_status_t      fifo_status,
    output logic              push,
    output logic [VAL_W-1:0]  push_value
);

    logic                valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                take;

    // holding stage drains into the queue; refill in the same cycle
    assign push          = valid_reg && !fifo_status.full;
    assign samples.ready = !valid_reg || !fifo_status.full;
    assign take          = samples.valid && samples.ready;

    // 10 x 16 bits always fits the 26-bit value, no wrap
    assign push_value = VAL_W'(sample_reg) * VAL_W'(gain);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sample_reg <= samples.sample;
        end
    end

endmodule

// ===== sv/swst_fifo.sv =====
module swst_fifo
    import swst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [VAL_W-1:0] wdata,
    input  logic             pop,
    output logic [VAL_W-1:0] rdata,
    output fifo_status_t     status
);

    logic [VAL_W-1:0]      mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    assign status.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign rdata        = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== sv/swst_back.sv =====
module swst_back
    import swst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  swst_cfg_t        cfg,
    input  fifo_status_t     fifo_status,
    input  logic [VAL_W-1:0] head_value,
    output logic             pop,
    swst_out_if.source       results
);

    // window state: entry 0 newest
    logic [VAL_W-1:0]  win_reg [WINDOW_LEN];
    logic [SUM_W-1:0]  sum_reg;
    logic [VAL_W-1:0]  low_reg;
    logic [VAL_W-1:0]  high_reg;

    // stage 1: updated stats
    logic              s1_valid_reg;
    logic [VAL_W-1:0]  s1_value_reg;
    logic [VAL_W-1:0]  s1_min_reg;
    logic [VAL_W-1:0]  s1_max_reg;
    trend_t            s1_trend_reg;
    logic [SUM_W-1:0]  s1_sum_reg;

    // stage 2: reciprocal product
    logic              s2_valid_reg;
    logic [VAL_W-1:0]  s2_value_reg;
    logic [VAL_W-1:0]  s2_min_reg;
    logic [VAL_W-1:0]  s2_max_reg;
    trend_t            s2_trend_reg;
    logic [SUM_W-1:0]  s2_sum_reg;
    logic [PROD_W-1:0] s2_prod_reg;

    // output stage
    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic [VAL_W-1:0]  out_mean_reg;
    logic [VAL_W-1:0]  out_min_reg;
    logic [VAL_W-1:0]  out_max_reg;
    trend_t            out_trend_reg;

    logic              advance;
    logic [SUM_W-1:0]  sum_next;
    logic [VAL_W-1:0]  low_next;
    logic [VAL_W-1:0]  high_next;
    logic [VAL_W:0]    cur_ext;
    logic [VAL_W:0]    prev_ext;
    logic [VAL_W:0]    thr_ext;
    logic              rise;
    logic              fall;
    trend_t            trend_next;
    logic [SUM_W-1:0]  quot_est;
    logic [SUM_W-1:0]  rem_est;
    logic [SUM_W-1:0]  mean_next;

    // whole pipe moves when the output slot is free or being taken
    assign advance = !out_valid_reg || results.ready;
    assign pop     = advance && !fifo_status.empty;

    assign sum_next  = sum_reg + SUM_W'(head_value) - SUM_W'(win_reg[WINDOW_LEN-1]);
    assign low_next  = (head_value < low_reg)  ? head_value : low_reg;
    assign high_next = (head_value > high_reg) ? head_value : high_reg;

    // dead band is exclusive at both edges
    assign cur_ext  = {1'b0, head_value};
    assign prev_ext = {1'b0, win_reg[0]};
    assign thr_ext  = {1'b0, cfg.threshold};
    assign rise     = cur_ext > (prev_ext + thr_ext);
    assign fall     = prev_ext > (cur_ext + thr_ext);

    always_comb
    begin
        priority if (fall)
        begin
            trend_next = cfg.invert ? TREND_RISING : TREND_FALLING;
        end
        else if (rise)
        begin
            trend_next = cfg.invert ? TREND_FALLING : TREND_RISING;
        end
        else
        begin
            trend_next = TREND_STABLE;
        end
    end

    // estimate is floor(sum/N) or one less; one compare fixes it
    assign quot_est  = s2_prod_reg[PROD_W-1:SUM_W];
    assign rem_est   = s2_sum_reg - quot_est * SUM_W'(WINDOW_LEN);
    assign mean_next = (rem_est >= SUM_W'(WINDOW_LEN)) ? quot_est + 1'b1 : quot_est;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
            sum_reg       <= '0;
            low_reg       <= '1;
            high_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (pop)
            begin
                for (int i = WINDOW_LEN - 1; i > 0; i--)
                begin
                    win_reg[i] <= win_reg[i-1];
                end
                win_reg[0] <= head_value;
                sum_reg    <= sum_next;
                low_reg    <= low_next;
                high_reg   <= high_next;
            end
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_value_reg  <= head_value;
            s1_min_reg    <= low_next;
            s1_max_reg    <= high_next;
            s1_trend_reg  <= trend_next;
            s1_sum_reg    <= sum_next;

            s2_value_reg  <= s1_value_reg;
            s2_min_reg    <= s1_min_reg;
            s2_max_reg    <= s1_max_reg;
            s2_trend_reg  <= s1_trend_reg;
            s2_sum_reg    <= s1_sum_reg;
            s2_prod_reg   <= PROD_W'(s1_sum_reg) * PROD_W'(RECIP);

            out_value_reg <= s2_value_reg;
            out_mean_reg  <= mean_next[VAL_W-1:0];
            out_min_reg   <= s2_min_reg;
            out_max_reg   <= s2_max_reg;
            out_trend_reg <= s2_trend_reg;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.value   = out_value_reg;
    assign results.mean    = out_mean_reg;
    assign results.minimum = out_min_reg;
    assign results.maximum = out_max_reg;
    assign results.trend   = out_trend_reg;

endmodule

// ===== sv/swst_checker.sv =====
`include "sensor_window_stats_trend_defines.svh"

module swst_checker
    import swst_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [VAL_W-1:0] out_value,
    input logic [VAL_W-1:0] out_mean,
    input logic [VAL_W-1:0] out_minimum,
    input logic [VAL_W-1:0] out_maximum
);

    // stalled result word holds its valid, value and mean
    `SWST_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_mean))

    `SWST_ASSERT_NOW(a_min_le_max, clk, rst_n, out_valid, out_minimum <= out_maximum)

    `SWST_ASSERT_NOW(a_value_in_range, clk, rst_n, out_valid, (out_value >= out_minimum) && (out_value <= out_maximum))

    // every window slot is zero or a seen value, so the mean cannot pass the max
    `SWST_ASSERT_NOW(a_mean_le_max, clk, rst_n, out_valid, out_mean <= out_maximum)

endmodule

bind sensor_window_stats_trend swst_checker u_swst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_value   (results.value),
    .out_mean    (results.mean),
    .out_minimum (results.minimum),
    .out_maximum (results.maximum)
);

// ===== test/tb_sensor_window_stats_trend.sv =====
module tb_sensor_window_stats_trend;
    import swst_pkg::*;

    // index 3 decodes to no register, so a write there must change nothing
    localparam logic [1:0]       REG_UNUSED    = 2'd3;
    localparam logic [VAL_W-1:0] THRESHOLD_MAX = 26'd67042305;
    localparam int               WORDS_PER_RUN = 325;
    localparam int               RUNS          = 6;
    localparam int               SETTLE_CYCLES = 12;
    localparam int               PRINT_CAP     = 200;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] mean;
        logic [VAL_W-1:0] minimum;
        logic [VAL_W-1:0] maximum;
        trend_t           trend;
    } stats_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    swst_in_if  samples_if ();
    swst_out_if results_if ();

    sensor_window_stats_trend dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the register file; only touched while the block is idle.
    logic [GAIN_W-1:0] cfg_gain;
    logic [VAL_W-1:0]  cfg_threshold;
    logic              cfg_invert;

    // Shadow of the block state: window (entry 0 newest) and running extremes.
    logic [VAL_W-1:0] hist [WINDOW_LEN];
    logic [VAL_W-1:0] low_mark;
    logic [VAL_W-1:0] high_mark;

    logic [SAMPLE_W-1:0] raw_codes [$];   // codes waiting to go out on the sample port
    stats_t              stats_due [$];   // predicted result words, oldest first
    int                  in_flight  = 0;  // codes queued whose result word has not come back
    int                  mismatches = 0;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    logic                code_taken = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Predicts one result word and advances the shadow state.
    function automatic stats_t scale_and_track(logic [SAMPLE_W-1:0] code);
        stats_t            s;
        logic [VAL_W+2:0]  total;
        longint            delta;
        s.value = {16'd0, code} * {10'd0, cfg_gain};  // max 1023*65535 fits in 26 bits
        for (int i = WINDOW_LEN - 1; i > 0; i--)
            hist[i] = hist[i-1];
        hist[0] = s.value;
        total = '0;
        for (int i = 0; i < WINDOW_LEN; i++)
            total += hist[i];
        s.mean = VAL_W'(total / WINDOW_LEN);
        // dead band is exclusive: a step of exactly +/- threshold stays stable
        delta = longint'(hist[0]) - longint'(hist[1]);
        if (delta < -longint'(cfg_threshold))
            s.trend = TREND_FALLING;
        else if (delta > longint'(cfg_threshold))
            s.trend = TREND_RISING;
        else
            s.trend = TREND_STABLE;
        if (cfg_invert)
        begin
            if (s.trend == TREND_RISING)
                s.trend = TREND_FALLING;
            else if (s.trend == TREND_FALLING)
                s.trend = TREND_RISING;
        end
        if (s.value < low_mark)
            low_mark = s.value;
        if (s.value > high_mark)
            high_mark = s.value;
        s.minimum = low_mark;
        s.maximum = high_mark;
        return s;
    endfunction

    // Mix of rail values, uniform codes and small walks around the last code,
    // so the trend lands on both sides of the dead band.
    function automatic logic [SAMPLE_W-1:0] next_code(logic [SAMPLE_W-1:0] prev);
        int pick;
        int nxt;
        pick = $urandom_range(99);
        if (pick < 10)
            nxt = $urandom_range(1) ? 1023 : 0;
        else if (pick < 50)
            nxt = $urandom_range(1023);
        else
        begin
            nxt = int'(prev) + $urandom_range(16) - 8;
            if (nxt < 0)
                nxt = 0;
            if (nxt > 1023)
                nxt = 1023;
        end
        return SAMPLE_W'(nxt);
    endfunction

    function automatic void queue_code(logic [SAMPLE_W-1:0] code);
        raw_codes.push_back(code);
        in_flight++;
    endfunction

    task automatic report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t: %s got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // APB write: setup phase, then access phase until pready.
    task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GAIN:      cfg_gain      = data[GAIN_W-1:0];
            REG_THRESHOLD: cfg_threshold = data[VAL_W-1:0];
            REG_INVERT:    cfg_invert    = data[0];
            default:       ;
        endcase
    endtask

    // Wait until every queued code has produced its word, then let the pipe settle.
    task automatic drain();
        do @(negedge clk); while (in_flight != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Sample side: note the handshake at the edge, predict, drive on the falling edge.
    always @(posedge clk)
    begin
        code_taken = rst_n && samples_if.valid && samples_if.ready;
        if (code_taken)
            stats_due.push_back(scale_and_track(samples_if.sample));
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            samples_if.valid <= 1'b0;
        else if (!samples_if.valid || code_taken)
        begin
            if (raw_codes.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                samples_if.valid  <= 1'b1;
                samples_if.sample <= raw_codes.pop_front();
            end
            else
                samples_if.valid <= 1'b0;
        end
    end

    // Result side: random backpressure, and every accepted word against the oldest prediction.
    always @(negedge clk)
        results_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : result_check
        stats_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (stats_due.size() == 0)
                report("unexpected word, value", results_if.value, '0);
            else
            begin
                want = stats_due.pop_front();
                in_flight--;
                if (results_if.value !== want.value)
                    report("value", results_if.value, want.value);
                if (results_if.mean !== want.mean)
                    report("mean", results_if.mean, want.mean);
                if (results_if.minimum !== want.minimum)
                    report("minimum", results_if.minimum, want.minimum);
                if (results_if.maximum !== want.maximum)
                    report("maximum", results_if.maximum, want.maximum);
                if (results_if.trend !== want.trend)
                    report("trend", VAL_W'(results_if.trend), VAL_W'(want.trend));
            end
        end
    end

    initial
    begin : stimulus
        logic [SAMPLE_W-1:0] opening   [6] = '{10'd1023, 10'd1023, 10'd0, 10'd1, 10'd512, 10'd511};
        logic [SAMPLE_W-1:0] band_walk [6] = '{10'd10, 10'd11, 10'd13, 10'd12, 10'd10, 10'd10};
        logic [SAMPLE_W-1:0] code;
        logic [GAIN_W-1:0]   g;

        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        samples_if.valid  = 1'b0;
        samples_if.sample = '0;
        results_if.ready  = 1'b0;
        cfg_gain          = GAIN_RST;
        cfg_threshold     = THRESHOLD_RST;
        cfg_invert        = INVERT_RST;
        for (int i = 0; i < WINDOW_LEN; i++)
            hist[i] = '0;
        low_mark          = '1;
        high_mark         = '0;
        send_idle_pct     = 11;
        recv_idle_pct     = 66;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings; first word compares against the zeroed window,
        // mean sees a partly filled window.
        foreach (opening[i])
            queue_code(opening[i]);
        drain();

        // Unity gain and a one-count dead band: steps of exactly one count
        // sit on the band edge and must read stable.
        write_reg(REG_GAIN, 32'd4096);
        write_reg(REG_THRESHOLD, 32'd4096);
        write_reg(REG_INVERT, 32'd0);
        foreach (band_walk[i])
            queue_code(band_walk[i]);
        drain();

        // Same walk inverted: rising and falling swap, stable stays.
        write_reg(REG_INVERT, 32'd1);
        foreach (band_walk[i])
            queue_code(band_walk[i]);
        drain();

        // Full-scale gain, zero band; the unused slot write must be dropped.
        write_reg(REG_GAIN, 32'd65535);
        write_reg(REG_THRESHOLD, 32'd0);
        write_reg(REG_INVERT, 32'd0);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        queue_code(10'd1023);
        queue_code(10'd0);
        queue_code(10'd1023);
        queue_code(10'd1022);
        drain();

        // Zero gain flattens everything.
        write_reg(REG_GAIN, 32'd0);
        queue_code(10'd5);
        queue_code(10'd1023);
        drain();

        // Random runs, each under its own register setting and idle profile.
        code = 10'd512;
        for (int run = 0; run < RUNS; run++)
        begin
            send_idle_pct = (run < 2) ? 11 : (run < 4) ? 66 : 0;
            recv_idle_pct = (run < 2) ? 66 : (run < 4) ? 11 : 0;
            g = (run == 1) ? 16'hFFFF : GAIN_W'($urandom_range(65535));
            write_reg(REG_GAIN, DATA_W'(g));
            if (run == 1)
                write_reg(REG_THRESHOLD, DATA_W'(THRESHOLD_MAX));
            else if (run == 3)
                write_reg(REG_THRESHOLD, 32'd0);
            else if ($urandom_range(1))
                write_reg(REG_THRESHOLD, $urandom_range(THRESHOLD_MAX));
            else
                write_reg(REG_THRESHOLD, $urandom_range(64 * int'(g) + 1));  // near typical steps
            write_reg(REG_INVERT, DATA_W'(run % 2));
            for (int n = 0; n < WORDS_PER_RUN; n++)
            begin
                code = next_code(code);
                queue_code(code);
            end
            drain();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
